// ===== hw/rtl/vna_pkg.sv =====
// Shared types, opcodes and helpers for the vertex normal averager.
package vna_pkg;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef struct packed {
      logic signed [31:0] z;
      logic signed [31:0] y;
      logic signed [31:0] x;
   } vec3_type;

   typedef struct packed {
      logic       en;
      logic [1:0] slot;
      vec3_type   pos;
      vec3_type   nrm;
   } store_wr_type;

   localparam int unsigned ReqDataW = 208;
   localparam int unsigned RspDataW = 112;
   localparam int unsigned Recip3   = 43691;
   localparam int unsigned Recip3Sh = 17;
   localparam logic [15:0] TolReset = 16'd7;

   function automatic logic axis_near(logic signed [31:0] a, logic signed [31:0] b,
                                      logic [15:0] tol);
      logic signed [32:0] d;
      logic [32:0]        m;
      d = {a[31], a} - {b[31], b};
      m = d[32] ? 33'(-d) : 33'(d);
      return m < {17'd0, tol};
   endfunction

   function automatic logic corner_near(vec3_type c, vec3_type p, logic [15:0] tol);
      return axis_near(c.x, p.x, tol) && axis_near(c.y, p.y, tol) &&
             axis_near(c.z, p.z, tol);
   endfunction

endpackage

// ===== hw/rtl/vna_store.sv =====
// Corner and face normal memories, one write port, one registered read port.
module vna_store #(
   parameter int unsigned MAX_TRIANGLES = 1024,
   parameter int unsigned TW = 10
) (
   input  logic                  clock,
   input  vna_pkg::store_wr_type wr,
   input  logic [TW-1:0]         wr_addr,
   input  logic                  rd_en,
   input  logic [TW-1:0]         rd_addr,
   output vna_pkg::vec3_type     rd_pos [3],
   output vna_pkg::vec3_type     rd_nrm
);

   vna_pkg::vec3_type corner0_mem [MAX_TRIANGLES];
   vna_pkg::vec3_type corner1_mem [MAX_TRIANGLES];
   vna_pkg::vec3_type corner2_mem [MAX_TRIANGLES];
   vna_pkg::vec3_type normal_mem  [MAX_TRIANGLES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         normal_mem[wr_addr] <= wr.nrm;
         case (wr.slot)
            2'd0:    corner0_mem[wr_addr] <= wr.pos;
            2'd1:    corner1_mem[wr_addr] <= wr.pos;
            2'd2:    corner2_mem[wr_addr] <= wr.pos;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_pos[0] <= corner0_mem[rd_addr];
         rd_pos[1] <= corner1_mem[rd_addr];
         rd_pos[2] <= corner2_mem[rd_addr];
         rd_nrm    <= normal_mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/vna_div.sv =====
// Bit-serial signed divider, truncating toward zero, 32-bit quotient.
module vna_div #(
   parameter int unsigned SW = 43,
   parameter int unsigned CW = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [SW-1:0] dividend,
   input  logic [CW-1:0]        divisor,
   output logic                 busy,
   output logic [31:0]          quotient
);

   localparam int unsigned NW = $clog2(SW + 1);

   logic          busy_ff;
   logic [NW-1:0] cnt_ff;
   logic          neg_ff;
   logic [SW-1:0] quo_ff;
   logic [CW-1:0] rem_ff;
   logic [CW-1:0] div_ff;
   logic [CW:0]   trial;
   logic          ge;
   logic [CW-1:0] rem_in;

   assign trial  = {rem_ff, quo_ff[SW-1]};
   assign ge     = trial >= {1'b0, div_ff};
   assign rem_in = ge ? CW'(trial - {1'b0, div_ff}) : trial[CW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == NW'(1)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= NW'(SW);
         neg_ff <= dividend[SW-1];
         quo_ff <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - NW'(1);
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[SW-2:0], ge};
      end
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? 32'(-quo_ff) : 32'(quo_ff);

endmodule

// ===== hw/rtl/vertex_normal_averager_top.sv =====
// Vertex normal averager: load/clear/query control, triangle walk and result register.
// Load, clear: one cycle each, taken only when no query is in flight.
// Query: the stored triangles are walked, then the sums divided (no divide with no match);
// one triangle is read per cycle, then a bit-serial divide of 32+log2 bits.
// Bad index: the query skips the walk and divide. One item in flight at a time.
// Synchronous reset clears the fill count, overflow flag and tolerance (to 7).
module vertex_normal_averager_top #(
   parameter int unsigned MAX_TRIANGLES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // pos_x, pos_y, pos_z, face_nx, face_ny, face_nz, corner_index[11:0], pad
   input  logic [vna_pkg::ReqDataW-1:0]  req_tdata,
   // op[1:0]
   input  logic [1:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // avg_nx, avg_ny, avg_nz, match_count[10:0], pad
   output logic [vna_pkg::RspDataW-1:0]  rsp_tdata,
   // index_bad, store_overflowed
   output logic [1:0]                    rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [15:0]                   csr_data
);

   localparam int unsigned TW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int unsigned CW = $clog2(MAX_TRIANGLES + 1);
   localparam int unsigned SW = 32 + CW;
   localparam int unsigned RspW = vna_pkg::RspDataW;

   typedef enum logic [2:0] {
      ST_IDLE, ST_POS, ST_WALK, ST_DRAIN, ST_DIV, ST_OUT
   } state_type;

   state_type             state_ff;
   logic [15:0]           tol_ff;
   logic [CW-1:0]         tri_cnt_ff;
   logic [1:0]            slot_ff;
   logic                  ovf_ff;
   logic                  bad_ff;
   logic [1:0]            rem_ff;
   logic [CW-1:0]         walk_ff;
   vna_pkg::vec3_type     p_ff;
   logic                  v1_ff;
   logic                  v2_ff;
   logic                  m2_ff;
   vna_pkg::vec3_type     n2_ff;
   logic signed [SW-1:0]  sx_ff, sy_ff, sz_ff;
   logic [CW-1:0]         cnt_ff;
   logic                  rsp_valid_ff;
   logic [RspW-1:0]       rsp_data_ff;
   logic [1:0]            rsp_user_ff;

   vna_pkg::op_type       op;
   vna_pkg::vec3_type     in_pos, in_nrm;
   logic [11:0]           idx;
   logic [28:0]           prod;
   logic [11:0]           tri_q;
   logic [1:0]            rem_q;
   logic                  bad_q;
   logic                  accept;
   logic                  full;
   vna_pkg::store_wr_type wr;
   logic                  rd_en;
   logic [TW-1:0]         rd_addr;
   vna_pkg::vec3_type     rd_pos [3];
   vna_pkg::vec3_type     rd_nrm;
   logic                  match1;
   logic                  div_start;
   logic                  busy_x, busy_y, busy_z;
   logic [31:0]           qx, qy, qz;
   logic                  zero_res;

   assign op     = vna_pkg::op_type'(req_tuser);
   assign in_pos = '{x: req_tdata[31:0], y: req_tdata[63:32], z: req_tdata[95:64]};
   assign in_nrm = '{x: req_tdata[127:96], y: req_tdata[159:128], z: req_tdata[191:160]};
   assign idx    = req_tdata[203:192];
   assign prod   = 29'(idx) * 29'(vna_pkg::Recip3);
   assign tri_q  = 12'(prod >> vna_pkg::Recip3Sh);
   assign rem_q  = 2'(idx - 12'(tri_q * 12'd3));
   assign bad_q  = {1'b0, tri_q} >= 13'(tri_cnt_ff);

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign full       = tri_cnt_ff == CW'(MAX_TRIANGLES);
   assign csr_ready  = 1'b1;

   assign wr.en   = accept && op == vna_pkg::OP_LOAD && !full;
   assign wr.slot = slot_ff;
   assign wr.pos  = in_pos;
   assign wr.nrm  = in_nrm;

   assign rd_en   = (accept && op == vna_pkg::OP_QUERY) || state_ff == ST_WALK;
   assign rd_addr = (state_ff == ST_WALK) ? walk_ff[TW-1:0] : tri_q[TW-1:0];

   vna_store #(.MAX_TRIANGLES(MAX_TRIANGLES), .TW(TW)) u_store (
      .clock   (clock),
      .wr      (wr),
      .wr_addr (tri_cnt_ff[TW-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_pos  (rd_pos),
      .rd_nrm  (rd_nrm)
   );

   assign match1 = vna_pkg::corner_near(rd_pos[0], p_ff, tol_ff) ||
                   vna_pkg::corner_near(rd_pos[1], p_ff, tol_ff) ||
                   vna_pkg::corner_near(rd_pos[2], p_ff, tol_ff);

   assign div_start = state_ff == ST_DRAIN && !v1_ff && !v2_ff && cnt_ff != '0;

   vna_div #(.SW(SW), .CW(CW)) u_div_x (
      .clock(clock), .reset(reset), .start(div_start), .dividend(sx_ff),
      .divisor(cnt_ff), .busy(busy_x), .quotient(qx));
   vna_div #(.SW(SW), .CW(CW)) u_div_y (
      .clock(clock), .reset(reset), .start(div_start), .dividend(sy_ff),
      .divisor(cnt_ff), .busy(busy_y), .quotient(qy));
   vna_div #(.SW(SW), .CW(CW)) u_div_z (
      .clock(clock), .reset(reset), .start(div_start), .dividend(sz_ff),
      .divisor(cnt_ff), .busy(busy_z), .quotient(qz));

   assign zero_res = bad_ff || cnt_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tol_ff       <= vna_pkg::TolReset;
         tri_cnt_ff   <= '0;
         slot_ff      <= '0;
         ovf_ff       <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            tol_ff <= csr_data;
         end
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         v1_ff <= state_ff == ST_WALK;
         v2_ff <= v1_ff;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (op)
                     vna_pkg::OP_LOAD: begin
                        if (full) begin
                           ovf_ff <= 1'b1;
                        end else if (slot_ff == 2'd2) begin
                           slot_ff    <= '0;
                           tri_cnt_ff <= tri_cnt_ff + CW'(1);
                        end else begin
                           slot_ff <= slot_ff + 2'd1;
                        end
                     end
                     vna_pkg::OP_CLEAR: begin
                        tri_cnt_ff <= '0;
                        slot_ff    <= '0;
                        ovf_ff     <= 1'b0;
                     end
                     vna_pkg::OP_QUERY: begin
                        state_ff <= bad_q ? ST_OUT : ST_POS;
                     end
                     default: ;
                  endcase
               end
            end
            ST_POS:   state_ff <= ST_WALK;
            ST_WALK: begin
               if (walk_ff == CW'(tri_cnt_ff - CW'(1))) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!v1_ff && !v2_ff) begin
                  state_ff <= (cnt_ff == '0) ? ST_OUT : ST_DIV;
               end
            end
            ST_DIV: begin
               if (!busy_x && !busy_y && !busy_z) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bad_ff  <= bad_q;
         rem_ff  <= rem_q;
         walk_ff <= '0;
         cnt_ff  <= '0;
         sx_ff   <= '0;
         sy_ff   <= '0;
         sz_ff   <= '0;
      end
      if (state_ff == ST_POS) begin
         case (rem_ff)
            2'd0:    p_ff <= rd_pos[0];
            2'd1:    p_ff <= rd_pos[1];
            default: p_ff <= rd_pos[2];
         endcase
      end
      if (state_ff == ST_WALK) begin
         walk_ff <= walk_ff + CW'(1);
      end
      m2_ff <= match1;
      n2_ff <= rd_nrm;
      if (v2_ff && m2_ff) begin
         sx_ff  <= sx_ff + SW'(n2_ff.x);
         sy_ff  <= sy_ff + SW'(n2_ff.y);
         sz_ff  <= sz_ff + SW'(n2_ff.z);
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {5'd0, bad_ff ? 11'd0 : 11'(cnt_ff),
                         zero_res ? 32'd0 : qz,
                         zero_res ? 32'd0 : qy,
                         zero_res ? 32'd0 : qx};
         rsp_user_ff <= {ovf_ff, bad_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
